/* rtl/b64d_pkg.sv */
// Package for the base64/base64url decoder: character codes, the result
// queue entry type and the character-to-sextet lookup.
// No dependencies.
`default_nettype none
package b64d_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QIdxW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [7:0] ChPad   = 8'h3D;  // '='
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] ChDig0  = 8'h30;
  localparam logic [7:0] ChDig9  = 8'h39;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChUnder = 8'h5F;

  localparam logic [5:0] LoBase  = 6'd26;
  localparam logic [5:0] DigBase = 6'd52;
  localparam logic [5:0] Val62   = 6'd62;
  localparam logic [5:0] Val63   = 6'd63;

  // One queued group: up to three bytes, or a single error result.
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;  // 1..3
    logic        last;
    logic        err;
  } grp_t;

  typedef struct packed {
    logic       bad;
    logic [5:0] val;
  } sextet_t;

  function automatic sextet_t decode_char(input logic [7:0] ch);
    sextet_t    r;
    logic [7:0] d;
    r = '{bad: 1'b0, val: 6'd0};
    d = 8'd0;
    if (ch >= ChUpA && ch <= ChUpZ) begin
      d     = ch - ChUpA;
      r.val = d[5:0];
    end else if (ch >= ChLoA && ch <= ChLoZ) begin
      d     = ch - ChLoA;
      r.val = d[5:0] + LoBase;
    end else if (ch >= ChDig0 && ch <= ChDig9) begin
      d     = ch - ChDig0;
      r.val = d[5:0] + DigBase;
    end else if (ch == ChPlus || ch == ChMinus) begin
      r.val = Val62;
    end else if (ch == ChSlash || ch == ChUnder) begin
      r.val = Val63;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/b64d_in_if.sv */
// Input channel of the decoder: one character and its final flag per transfer.
// No dependencies.
`default_nettype none
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       final_char;

  modport source (output valid, output char_code, output final_char, input ready);
  modport sink   (input valid, input char_code, input final_char, output ready);
endinterface
`default_nettype wire

/* rtl/b64d_out_if.sv */
// Output channel of the decoder: one decoded byte with status per transfer.
// No dependencies.
`default_nettype none
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       status;
  logic       end_of_message;

  modport source (output valid, output data_byte, output status, output end_of_message,
                  input ready);
  modport sink   (input valid, input data_byte, input status, input end_of_message,
                  output ready);
endinterface
`default_nettype wire

/* rtl/base64url_decoder.sv */
// Streaming base64 / base64url decoder, top level.
// Depends on b64d_pkg, b64d_in_if and b64d_out_if.
//
// Usage:
//   in_i  : one ASCII character per transfer, final_char marks the end of a
//           message. Both '+' '/' and '-' '_' are taken; '=' is padding.
//   out_o : one decoded byte per transfer. end_of_message flags the last byte
//           of a message. An invalid character gives one result with
//           status = 1, data_byte = 0, end_of_message = 1, and the rest of
//           that message is discarded up to its final character.
//   The character that completes (or ends) a group is held in the input
//   register; the group then goes into the result queue that feeds out_o.
//   Throughput: one character per cycle. A group yields up to three bytes,
//   drained one per cycle from a four-group result queue; the input stalls
//   only when that queue is full, i.e. when the receiver holds off ready.
//   Reset clears the input register, the group state and the queue.
//   A stalled receiver keeps the head byte steady and lets the queue fill,
//   after which in_i.ready drops.
`default_nettype none
module base64url_decoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  b64d_in_if.sink   in_i,
  b64d_out_if.source out_o
);
  import b64d_pkg::*;

  // input register
  logic       in_vld_q;
  logic [7:0] in_ch_q;
  logic       in_fin_q;

  // group state
  logic [23:0] bits_q, bits_d;
  logic [1:0]  pos_q, pos_d;
  logic [2:0]  pad_q, pad_d;
  logic        drop_q, drop_d;

  // result queue
  grp_t              q_mem [QDepth];
  logic [QIdxW-1:0]  wr_q, rd_q;
  logic [QCntW-1:0]  cnt_q;
  logic [1:0]        bidx_q;

  logic    q_full, proc, push, pop;
  grp_t    push_ent, head;
  sextet_t sx;
  logic [23:0] nb;
  logic [1:0]  npos;
  logic [2:0]  npad;

  assign q_full    = (cnt_q == QCntW'(QDepth));
  assign proc      = in_vld_q && !q_full;
  assign in_i.ready = !in_vld_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_ch_q  <= in_i.char_code;
      in_fin_q <= in_i.final_char;
    end
  end

  function automatic logic [1:0] byte_count(input logic [2:0] pads);
    logic [1:0] n;
    case (pads)
      3'd0:    n = 2'd3;
      3'd1:    n = 2'd2;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

  always_comb begin
    bits_d   = bits_q;
    pos_d    = pos_q;
    pad_d    = pad_q;
    drop_d   = drop_q;
    push     = 1'b0;
    push_ent = '{bits: 24'd0, nbytes: 2'd1, last: 1'b1, err: 1'b1};
    sx       = decode_char(in_ch_q);
    nb       = bits_q;
    npos     = pos_q;
    npad     = pad_q;
    if (proc) begin
      if (drop_q) begin
        if (in_fin_q) begin
          drop_d = 1'b0;
          bits_d = 24'd0;
          pos_d  = 2'd0;
          pad_d  = 3'd0;
        end
      end else if (in_ch_q != ChPad && sx.bad) begin
        push   = 1'b1;
        drop_d = !in_fin_q;
        bits_d = 24'd0;
        pos_d  = 2'd0;
        pad_d  = 3'd0;
      end else begin
        if (in_ch_q == ChPad) begin
          nb   = {bits_q[17:0], 6'd0};
          npad = pad_q + 3'd1;
        end else begin
          nb   = {bits_q[17:0], sx.val};
        end
        npos = pos_q + 2'd1;
        if (npos != 2'd0 && in_fin_q) begin
          // pad out the missing positions
          case (npos)
            2'd1:    begin nb = {nb[5:0],  18'd0}; npad = npad + 3'd3; end
            2'd2:    begin nb = {nb[11:0], 12'd0}; npad = npad + 3'd2; end
            default: begin nb = {nb[17:0],  6'd0}; npad = npad + 3'd1; end
          endcase
        end
        if (npos == 2'd0 || in_fin_q) begin
          push     = 1'b1;
          push_ent = '{bits: nb, nbytes: byte_count(npad), last: in_fin_q, err: 1'b0};
          bits_d   = 24'd0;
          pos_d    = 2'd0;
          pad_d    = 3'd0;
        end else begin
          bits_d = nb;
          pos_d  = npos;
          pad_d  = npad;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= 24'd0;
      pos_q  <= 2'd0;
      pad_q  <= 3'd0;
      drop_q <= 1'b0;
    end else begin
      bits_q <= bits_d;
      pos_q  <= pos_d;
      pad_q  <= pad_d;
      drop_q <= drop_d;
    end
  end

  // result queue and byte drain
  assign head = q_mem[rd_q];
  assign pop  = out_o.valid && out_o.ready && (bidx_q == head.nbytes - 2'd1);

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= push_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
      bidx_q <= 2'd0;
    end else begin
      if (push) wr_q <= wr_q + QIdxW'(1);
      if (pop)  rd_q <= rd_q + QIdxW'(1);
      cnt_q <= cnt_q + QCntW'(push) - QCntW'(pop);
      if (pop) begin
        bidx_q <= 2'd0;
      end else if (out_o.valid && out_o.ready) begin
        bidx_q <= bidx_q + 2'd1;
      end
    end
  end

  always_comb begin
    case (bidx_q)
      2'd0:    out_o.data_byte = head.bits[23:16];
      2'd1:    out_o.data_byte = head.bits[15:8];
      default: out_o.data_byte = head.bits[7:0];
    endcase
  end

  assign out_o.valid          = (cnt_q != '0);
  assign out_o.status         = head.err;
  assign out_o.end_of_message = head.last && (bidx_q == head.nbytes - 2'd1);

  // checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue count overflow");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("push into full result queue");

  a_bidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (bidx_q < head.nbytes))
    else $error("byte index past group size");

  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status) |-> (out_o.end_of_message && out_o.data_byte == 8'd0))
    else $error("error result malformed");

  a_drop_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && drop_q) |-> !push)
    else $error("result produced while dropping");

endmodule
`default_nettype wire
